// ===== src/cwu_pkg.sv =====
// Package for the constant-weight code unranking block.
// Holds widths, register indexes, sequencer states and the shared ALU request types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cwu_pkg;

    localparam int MAX_LENGTH = 64;
    localparam int DATA_W     = 64;
    localparam int LEN_W      = 7;
    localparam int POS_W      = 6;
    localparam int TAB_ADDR_W = 2 * POS_W;
    localparam int TAB_DEPTH  = 1 << TAB_ADDR_W;

    localparam logic [POS_W-1:0] POS_MAX    = POS_W'(MAX_LENGTH - 1);
    localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_LENGTH);

    // configuration register indexes
    localparam logic REG_CODE_LENGTH = 1'b0;
    localparam logic REG_CODE_WEIGHT = 1'b1;

    localparam logic [LEN_W-1:0] CODE_LENGTH_RST = 7'd16;
    localparam logic [LEN_W-1:0] CODE_WEIGHT_RST = 7'd2;

    typedef enum logic [3:0] {
        ST_FILL_ROW0,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_IDLE,
        ST_TOT_A,
        ST_TOT_B,
        ST_TOT_ADD,
        ST_CMP,
        ST_MOD,
        ST_SCAN_RD,
        ST_SCAN_EX,
        ST_DONE
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              borrow;
    } alu_rsp_t;

endpackage

`default_nettype wire

// ===== src/cwu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module cwu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/cwu_alu.sv =====
// Shared 64-bit add/subtract unit with borrow output.
// Depends on cwu_pkg for the request and response types.
`timescale 1ns / 1ps
`default_nettype none

module cwu_alu (
    input  wire cwu_pkg::alu_req_t req,
    output cwu_pkg::alu_rsp_t      rsp
);

    import cwu_pkg::*;

    logic [DATA_W:0] wide;

    always_comb
    begin
        case (req.op)
            ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
            default: wide = {1'b0, req.a} - {1'b0, req.b};
        endcase
        rsp.result = wide[DATA_W-1:0];
        rsp.borrow = wide[DATA_W];
    end

endmodule

`default_nettype wire

// ===== src/constant_weight_code_unrank.sv =====
// Constant-weight code unranking: sequencer, binomial table and shared ALU.
// Sequence: table reads for the total, a compare, a modulo reduction when the rank wraps,
// a read and an execute step per scanned position, and a step to register the result;
// a weight above the length goes straight to the result.
// Flow: one transaction at a time; the next is taken the cycle after the result is
// registered, and registering waits while the previous result is held by a stall.
// Reset: asynchronous, active low; afterwards a pass builds the binomial table by Pascal's
// rule, and no input is taken until it completes (configuration is always taken).
`timescale 1ns / 1ps
`default_nettype none

module constant_weight_code_unrank (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [cwu_pkg::LEN_W-1:0]   cfg_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [cwu_pkg::DATA_W-1:0]  s_tdata,   // [63:0] rank
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [cwu_pkg::DATA_W-1:0]  m_tdata,   // [63:0] codeword
    output logic      [1:0]                  m_tuser    // [0] wrapped, [1] bad_config
);

    import cwu_pkg::*;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  n_reg, n_next;
    logic [POS_W-1:0]  k_reg, k_next;
    logic [DATA_W-1:0] prev_reg, prev_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  w_reg, w_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic [DATA_W-1:0] total_reg, total_next;
    logic [DATA_W-1:0] tmp_reg, tmp_next;
    logic [POS_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] word_reg, word_next;
    logic              wrapped_reg, wrapped_next;
    logic              bad_reg, bad_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg;
    logic [1:0]        m_tuser_reg;
    logic [LEN_W-1:0]  code_length_reg;
    logic [LEN_W-1:0]  code_weight_reg;

    logic                  out_load;
    logic                  ram_we;
    logic [TAB_ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0]     ram_wdata;
    logic [TAB_ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0]     ram_rdata;
    alu_req_t              alu_req;
    alu_rsp_t              alu_rsp;

    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  len_dec;
    logic [LEN_W-1:0]  w_dec;
    logic [DATA_W-1:0] fill_a;
    logic [DATA_W-1:0] mod_shift;
    logic [DATA_W-1:0] mod_r;

    assign len_eff   = (code_length_reg > LEN_MAX) ? LEN_MAX : code_length_reg;
    assign len_dec   = len_reg - 7'd1;
    assign w_dec     = w_reg - 7'd1;
    assign fill_a    = (k_reg < n_reg) ? ram_rdata : '0;
    assign mod_shift = {r_reg[DATA_W-2:0], rem_reg[DATA_W-1]};
    assign mod_r     = alu_rsp.borrow ? mod_shift : alu_rsp.result;

    cwu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TAB_DEPTH)
    ) u_tab (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cwu_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        prev_next     = prev_reg;
        len_next      = len_reg;
        w_next        = w_reg;
        rem_next      = rem_reg;
        r_next        = r_reg;
        total_next    = total_reg;
        tmp_next      = tmp_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        word_next     = word_reg;
        wrapped_next  = wrapped_reg;
        bad_next      = bad_reg;
        out_load      = 1'b0;
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = {n_reg, k_reg};
        ram_wdata     = alu_rsp.result;
        ram_raddr     = {pos_reg, w_reg[POS_W-1:0]};
        alu_req.op    = ALU_SUB;
        alu_req.a     = rem_reg;
        alu_req.b     = total_reg;

        case (state_reg)
            ST_FILL_ROW0:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = 64'd1;
                n_next     = 6'd1;
                k_next     = '0;
                prev_next  = '0;
                state_next = ST_FILL_RD;
            end
            ST_FILL_RD:
            begin
                ram_raddr  = {n_reg - 6'd1, k_reg};
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = fill_a;
                alu_req.b  = prev_reg;
                ram_we     = 1'b1;
                prev_next  = fill_a;
                state_next = ST_FILL_RD;
                if (k_reg == n_reg)
                begin
                    k_next    = '0;
                    prev_next = '0;
                    if (n_reg == POS_MAX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        n_next = n_reg + 6'd1;
                    end
                end
                else
                begin
                    k_next = k_reg + 6'd1;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    rem_next     = s_tdata;
                    len_next     = len_eff;
                    w_next       = code_weight_reg;
                    word_next    = '0;
                    wrapped_next = 1'b0;
                    bad_next     = code_weight_reg > len_eff;
                    if (code_weight_reg > len_eff)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (len_eff == '0)
                    begin
                        total_next = 64'd1;
                        state_next = ST_CMP;
                    end
                    else
                    begin
                        state_next = ST_TOT_A;
                    end
                end
            end
            ST_TOT_A:
            begin
                ram_raddr  = {len_dec[POS_W-1:0], w_reg[POS_W-1:0]};
                state_next = ST_TOT_B;
            end
            ST_TOT_B:
            begin
                ram_raddr  = {len_dec[POS_W-1:0], w_dec[POS_W-1:0]};
                tmp_next   = (w_reg < len_reg) ? ram_rdata : '0;
                state_next = ST_TOT_ADD;
            end
            ST_TOT_ADD:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = tmp_reg;
                alu_req.b  = (w_reg != '0) ? ram_rdata : '0;
                total_next = alu_rsp.result;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!alu_rsp.borrow)
                begin
                    wrapped_next = 1'b1;
                    r_next       = '0;
                    cnt_next     = '0;
                    state_next   = ST_MOD;
                end
                else if (len_reg == '0 || w_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    pos_next   = len_dec[POS_W-1:0];
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MOD:
            begin
                alu_req.a = mod_shift;
                r_next    = mod_r;
                rem_next  = {rem_reg[DATA_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == POS_MAX)
                begin
                    rem_next = mod_r;
                    if (len_reg == '0 || w_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        pos_next   = len_dec[POS_W-1:0];
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_EX;
            end
            ST_SCAN_EX:
            begin
                alu_req.b  = ({1'b0, pos_reg} < w_reg) ? '0 : ram_rdata;
                state_next = ST_SCAN_RD;
                pos_next   = pos_reg - 6'd1;
                if (!alu_rsp.borrow)
                begin
                    word_next = word_reg | (64'd1 << pos_reg);
                    rem_next  = alu_rsp.result;
                    w_next    = w_dec;
                end
                if (pos_reg == '0 || (!alu_rsp.borrow && w_reg == 7'd1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL_ROW0;
            n_reg        <= '0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_length_reg <= CODE_LENGTH_RST;
            code_weight_reg <= CODE_WEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CODE_LENGTH: code_length_reg <= cfg_data;
                REG_CODE_WEIGHT: code_weight_reg <= cfg_data;
                default:         code_length_reg <= code_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg    <= prev_next;
        len_reg     <= len_next;
        w_reg       <= w_next;
        rem_reg     <= rem_next;
        r_reg       <= r_next;
        total_reg   <= total_next;
        tmp_reg     <= tmp_next;
        cnt_reg     <= cnt_next;
        pos_reg     <= pos_next;
        word_reg    <= word_next;
        wrapped_reg <= wrapped_next;
        bad_reg     <= bad_next;
        if (out_load)
        begin
            m_tdata_reg <= word_reg;
            m_tuser_reg <= {bad_reg, wrapped_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== src/cwu_checker.sv =====
// Port-level checker for the constant-weight code unranking block, bound to the top level.
// Depends on cwu_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module cwu_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [cwu_pkg::DATA_W-1:0] m_tdata,
    input wire logic [1:0]                 m_tuser
);

    import cwu_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a bad configuration gives an empty, unwrapped word
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[0])
        else $error("bad_config with nonzero codeword or wrapped set");

    // drop ready once a transaction is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // a new result only follows a busy period
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work");

endmodule

bind constant_weight_code_unrank cwu_checker u_cwu_checker (.*);

`default_nettype wire
